[design/mvd_pkg.sv]
// ---------------------------------------------------------------------------
// Multiply/divide unit package
// Shared types, operation codes and sizing constants.
// ---------------------------------------------------------------------------
package mvd_pkg;

   localparam int XLEN = 64;
   localparam int QUEUE_DEPTH_DEFAULT = 2;

   localparam logic [3:0] KIND_MUL    = 4'd0;
   localparam logic [3:0] KIND_MULH   = 4'd1;
   localparam logic [3:0] KIND_MULHSU = 4'd2;
   localparam logic [3:0] KIND_MULHU  = 4'd3;
   localparam logic [3:0] KIND_DIV    = 4'd4;
   localparam logic [3:0] KIND_DIVU   = 4'd5;
   localparam logic [3:0] KIND_REM    = 4'd6;
   localparam logic [3:0] KIND_REMU   = 4'd7;
   localparam logic [3:0] KIND_MULW   = 4'd8;
   localparam logic [3:0] KIND_DIVW   = 4'd9;
   localparam logic [3:0] KIND_DIVUW  = 4'd10;
   localparam logic [3:0] KIND_REMW   = 4'd11;
   localparam logic [3:0] KIND_REMUW  = 4'd12;

   typedef struct packed {
      logic [3:0]  kind;
      logic [63:0] operand_a;
      logic [63:0] operand_b;
      logic [4:0]  dest_reg;
   } req_type;

   typedef struct packed {
      logic [63:0] result_value;
      logic [4:0]  result_dest;
   } rsp_type;

   typedef struct packed {
      logic is_mul;
      logic mul_high;
      logic is_word;
      logic want_rem;
      logic neg_res;
      logic zero_res;
   } ctl_type;

   typedef struct packed {
      ctl_type     ctl;
      logic [63:0] op_x;
      logic [63:0] op_y;
      logic [63:0] corr;
      logic [4:0]  dest;
   } dec_type;

endpackage

[design/mvd_fifo.sv]
// ---------------------------------------------------------------------------
// Register queue
// Small first-in first-out queue built from registers.
// ---------------------------------------------------------------------------
module mvd_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic [WIDTH-1:0] pop_data,
   output logic             empty
);

   localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CW = $clog2(DEPTH + 1);
   localparam logic [PW-1:0] LAST = PW'(DEPTH - 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in, rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;
   logic             do_push, do_pop;

   assign full     = (count_ff == CW'(DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push & ~full;
   assign do_pop   = pop & ~empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

[design/mvd_front.sv]
// ---------------------------------------------------------------------------
// Multiply/divide front end
// Classifies an operation and prepares operands, signs and corrections.
// ---------------------------------------------------------------------------
module mvd_front (
   input  mvd_pkg::req_type req,
   output mvd_pkg::dec_type dec
);

   logic        sgn, word, sa, sb;
   logic [63:0] ax, bx;

   always_comb begin
      dec      = '0;
      dec.dest = req.dest_reg;
      word     = (req.kind == mvd_pkg::KIND_DIVW) || (req.kind == mvd_pkg::KIND_DIVUW) ||
                 (req.kind == mvd_pkg::KIND_REMW) || (req.kind == mvd_pkg::KIND_REMUW);
      sgn      = (req.kind == mvd_pkg::KIND_DIV) || (req.kind == mvd_pkg::KIND_REM) ||
                 (req.kind == mvd_pkg::KIND_DIVW) || (req.kind == mvd_pkg::KIND_REMW);
      if (word) begin
         ax = sgn ? {{32{req.operand_a[31]}}, req.operand_a[31:0]}
                  : {32'b0, req.operand_a[31:0]};
         bx = sgn ? {{32{req.operand_b[31]}}, req.operand_b[31:0]}
                  : {32'b0, req.operand_b[31:0]};
      end else begin
         ax = req.operand_a;
         bx = req.operand_b;
      end
      sa = sgn & ax[63];
      sb = sgn & bx[63];
      case (req.kind)
         mvd_pkg::KIND_MUL, mvd_pkg::KIND_MULHU, mvd_pkg::KIND_MULW,
         mvd_pkg::KIND_MULH, mvd_pkg::KIND_MULHSU: begin
            dec.ctl.is_mul   = 1'b1;
            dec.ctl.mul_high = (req.kind == mvd_pkg::KIND_MULH) ||
                               (req.kind == mvd_pkg::KIND_MULHSU) ||
                               (req.kind == mvd_pkg::KIND_MULHU);
            dec.ctl.is_word  = (req.kind == mvd_pkg::KIND_MULW);
            dec.op_x         = req.operand_a;
            dec.op_y         = req.operand_b;
            if (req.kind == mvd_pkg::KIND_MULH) begin
               dec.corr = (req.operand_a[63] ? req.operand_b : 64'b0) +
                          (req.operand_b[63] ? req.operand_a : 64'b0);
            end else if (req.kind == mvd_pkg::KIND_MULHSU) begin
               dec.corr = req.operand_a[63] ? req.operand_b : 64'b0;
            end
         end
         mvd_pkg::KIND_DIV, mvd_pkg::KIND_DIVU, mvd_pkg::KIND_DIVW, mvd_pkg::KIND_DIVUW,
         mvd_pkg::KIND_REM, mvd_pkg::KIND_REMU, mvd_pkg::KIND_REMW,
         mvd_pkg::KIND_REMUW: begin
            dec.ctl.is_word  = word;
            dec.ctl.want_rem = (req.kind == mvd_pkg::KIND_REM) ||
                               (req.kind == mvd_pkg::KIND_REMU) ||
                               (req.kind == mvd_pkg::KIND_REMW) ||
                               (req.kind == mvd_pkg::KIND_REMUW);
            dec.op_x         = sa ? (64'b0 - ax) : ax;
            dec.op_y         = sb ? (64'b0 - bx) : bx;
            if (dec.ctl.want_rem) begin
               dec.ctl.neg_res = sa;
            end else begin
               dec.ctl.neg_res = (sa ^ sb) & (bx != 64'b0);
            end
         end
         default: begin
            dec.ctl.zero_res = 1'b1;
         end
      endcase
   end

endmodule

[design/mvd_back.sv]
// ---------------------------------------------------------------------------
// Multiply/divide back end
// Pipelined multiplier beside a one-bit-per-stage restoring divider.
// ---------------------------------------------------------------------------
module mvd_back (
   input  logic             clock,
   input  logic             reset,
   input  mvd_pkg::dec_type head,
   input  logic             head_empty,
   output logic             head_pop,
   input  logic             out_full,
   output logic             out_push,
   output mvd_pkg::rsp_type out_data
);

   localparam int N = mvd_pkg::XLEN;

   typedef struct packed {
      logic             valid;
      mvd_pkg::ctl_type ctl;
      logic [4:0]       dest;
      logic [63:0]      rem;
      logic [63:0]      quo;
      logic [63:0]      dvs;
      logic [63:0]      mres;
   } stg_type;

   typedef struct packed {
      logic [63:0] ll;
      logic [63:0] lh;
      logic [63:0] hl;
      logic [63:0] hh;
      logic [63:0] corr;
   } m1_type;

   typedef struct packed {
      logic [63:0] ll;
      logic [64:0] mid;
      logic [63:0] hh;
      logic [63:0] corr;
   } m2_type;

   typedef struct packed {
      logic [127:0] p;
      logic [63:0]  corr;
   } m3_type;

   stg_type stg_ff [N];
   stg_type stg_in [N];
   m1_type  m1_ff, m1_in;
   m2_type  m2_ff, m2_in;
   m3_type  m3_ff, m3_in;
   logic    en;
   stg_type fin;
   logic [63:0] res;

   assign en       = ~out_full;
   assign head_pop = en & ~head_empty;

   always_comb begin
      stg_type     src;
      logic [64:0] r65, diff;
      logic [63:0] hi;
      m1_in.ll   = 64'(head.op_x[31:0]) * 64'(head.op_y[31:0]);
      m1_in.lh   = 64'(head.op_x[31:0]) * 64'(head.op_y[63:32]);
      m1_in.hl   = 64'(head.op_x[63:32]) * 64'(head.op_y[31:0]);
      m1_in.hh   = 64'(head.op_x[63:32]) * 64'(head.op_y[63:32]);
      m1_in.corr = head.corr;
      m2_in.ll   = m1_ff.ll;
      m2_in.mid  = {1'b0, m1_ff.lh} + {1'b0, m1_ff.hl};
      m2_in.hh   = m1_ff.hh;
      m2_in.corr = m1_ff.corr;
      m3_in.p    = {m2_ff.hh, m2_ff.ll} + {31'b0, m2_ff.mid, 32'b0};
      m3_in.corr = m2_ff.corr;
      hi         = m3_ff.p[127:64] - m3_ff.corr;
      for (int k = 0; k < N; k++) begin
         if (k == 0) begin
            src.valid = ~head_empty;
            src.ctl   = head.ctl;
            src.dest  = head.dest;
            src.rem   = '0;
            src.quo   = head.op_x;
            src.dvs   = head.op_y;
            src.mres  = '0;
         end else begin
            src = stg_ff[k-1];
         end
         r65  = {src.rem, src.quo[63]};
         diff = r65 - {1'b0, src.dvs};
         stg_in[k]     = src;
         stg_in[k].rem = diff[64] ? r65[63:0] : diff[63:0];
         stg_in[k].quo = {src.quo[62:0], ~diff[64]};
         if (k == 3) begin
            if (src.ctl.mul_high) begin
               stg_in[k].mres = hi;
            end else if (src.ctl.is_word) begin
               stg_in[k].mres = {{32{m3_ff.p[31]}}, m3_ff.p[31:0]};
            end else begin
               stg_in[k].mres = m3_ff.p[63:0];
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < N; k++) begin
            stg_ff[k].valid <= 1'b0;
         end
      end else if (en) begin
         for (int k = 0; k < N; k++) begin
            stg_ff[k] <= stg_in[k];
         end
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
      end
   end

   assign fin = stg_ff[N-1];

   always_comb begin
      if (fin.ctl.is_mul) begin
         res = fin.mres;
      end else begin
         res = fin.ctl.want_rem ? fin.rem : fin.quo;
         if (fin.ctl.neg_res) begin
            res = 64'b0 - res;
         end
         if (fin.ctl.is_word) begin
            res = {{32{res[31]}}, res[31:0]};
         end
      end
      if (fin.ctl.zero_res) begin
         res = '0;
      end
      out_data.result_value = res;
      out_data.result_dest  = fin.dest;
   end

   assign out_push = en & fin.valid;

endmodule

[design/rv64m_mul_div_unit.sv]
// Every operation passes through the 64-stage restoring divider pipeline on its
// way from an accepted transaction to its result on rsp_data.
// Throughput: one transaction per cycle; the pipeline stalls only while the
// result queue is full.
// Reset: synchronous, active high; clears both queues and all stage valid bits.
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit
// Front end decodes into a short queue; back end executes and fills a result queue.
// ---------------------------------------------------------------------------
module rv64m_mul_div_unit #(
   parameter int QUEUE_DEPTH = mvd_pkg::QUEUE_DEPTH_DEFAULT
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   output logic             req_full,
   input  mvd_pkg::req_type req_data,
   output logic             rsp_empty,
   input  logic             rsp_pop,
   output mvd_pkg::rsp_type rsp_data
);

   mvd_pkg::dec_type dec, head;
   logic             head_empty, head_pop, out_full, out_push;
   mvd_pkg::rsp_type out_data;

   mvd_front u_front (
      .req (req_data),
      .dec (dec)
   );

   mvd_fifo #(
      .WIDTH ($bits(mvd_pkg::dec_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_dec_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (req_push),
      .push_data (dec),
      .full      (req_full),
      .pop       (head_pop),
      .pop_data  (head),
      .empty     (head_empty)
   );

   mvd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .head       (head),
      .head_empty (head_empty),
      .head_pop   (head_pop),
      .out_full   (out_full),
      .out_push   (out_push),
      .out_data   (out_data)
   );

   mvd_fifo #(
      .WIDTH ($bits(mvd_pkg::rsp_type)),
      .DEPTH (QUEUE_DEPTH)
   ) u_rsp_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (out_push),
      .push_data (out_data),
      .full      (out_full),
      .pop       (rsp_pop),
      .pop_data  (rsp_data),
      .empty     (rsp_empty)
   );

endmodule

[sim/rv64m_mul_div_checker.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit checker
// Watches both queue ports, predicts each result and compares it in order.
// ---------------------------------------------------------------------------
module rv64m_mul_div_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_push,
   input  logic             req_full,
   input  mvd_pkg::req_type req_data,
   input  logic             rsp_empty,
   input  logic             rsp_pop,
   input  mvd_pkg::rsp_type rsp_data,
   output int               error_count,
   output int               pending_count,
   output int               result_count
);

   localparam logic [63:0] LOW_MASK = 64'h0000_0000_FFFF_FFFF;
   localparam logic [63:0] MIN_SIGNED = 64'h8000_0000_0000_0000;
   localparam logic [63:0] ALL_ONES = 64'hFFFF_FFFF_FFFF_FFFF;

   mvd_pkg::rsp_type expected_results[$];

   function automatic logic [63:0] sign_extend_word(logic [63:0] x);
      return {{32{x[31]}}, x[31:0]};
   endfunction

   function automatic logic [63:0] signed_quotient(logic [63:0] a, logic [63:0] b);
      if (a == MIN_SIGNED && b == ALL_ONES) begin
         return a;
      end
      return $signed(a) / $signed(b);
   endfunction

   function automatic logic [63:0] signed_remainder(logic [63:0] a, logic [63:0] b);
      if (a == MIN_SIGNED && b == ALL_ONES) begin
         return '0;
      end
      return $signed(a) % $signed(b);
   endfunction

   function automatic logic [63:0] mul_div_result(mvd_pkg::req_type r);
      logic [127:0] product;
      logic [63:0] a;
      logic [63:0] b;
      logic [63:0] aw;
      logic [63:0] bw;
      a = r.operand_a;
      b = r.operand_b;
      aw = sign_extend_word(a);
      bw = sign_extend_word(b);
      case (r.kind)
         mvd_pkg::KIND_MUL: begin
            return a * b;
         end
         mvd_pkg::KIND_MULH: begin
            product = $signed({{64{a[63]}}, a}) * $signed({{64{b[63]}}, b});
            return product[127:64];
         end
         mvd_pkg::KIND_MULHSU: begin
            product = {{64{a[63]}}, a} * {64'd0, b};
            return product[127:64];
         end
         mvd_pkg::KIND_MULHU: begin
            product = {64'd0, a} * {64'd0, b};
            return product[127:64];
         end
         mvd_pkg::KIND_DIV: begin
            return (b == 0) ? ALL_ONES : signed_quotient(a, b);
         end
         mvd_pkg::KIND_DIVU: begin
            return (b == 0) ? ALL_ONES : a / b;
         end
         mvd_pkg::KIND_REM: begin
            return (b == 0) ? a : signed_remainder(a, b);
         end
         mvd_pkg::KIND_REMU: begin
            return (b == 0) ? a : a % b;
         end
         mvd_pkg::KIND_MULW: begin
            return sign_extend_word((a & LOW_MASK) * (b & LOW_MASK));
         end
         mvd_pkg::KIND_DIVW: begin
            return (bw == 0) ? ALL_ONES : sign_extend_word(signed_quotient(aw, bw));
         end
         mvd_pkg::KIND_DIVUW: begin
            return ((b & LOW_MASK) == 0) ? ALL_ONES
                                          : sign_extend_word((a & LOW_MASK) / (b & LOW_MASK));
         end
         mvd_pkg::KIND_REMW: begin
            return (bw == 0) ? aw : sign_extend_word(signed_remainder(aw, bw));
         end
         mvd_pkg::KIND_REMUW: begin
            return ((b & LOW_MASK) == 0) ? aw
                                          : sign_extend_word((a & LOW_MASK) % (b & LOW_MASK));
         end
         default: begin
            return '0;
         end
      endcase
   endfunction

   always @(posedge clock) begin
      mvd_pkg::rsp_type predicted;
      mvd_pkg::rsp_type oldest;
      if (reset) begin
         expected_results.delete();
         error_count <= 0;
         result_count <= 0;
         pending_count <= 0;
      end else begin
         if (req_push && !req_full) begin
            predicted.result_value = mul_div_result(req_data);
            predicted.result_dest = req_data.dest_reg;
            expected_results.push_back(predicted);
         end
         if (rsp_pop && !rsp_empty) begin
            result_count <= result_count + 1;
            if (expected_results.size() == 0) begin
               $error("unexpected transaction: value %h dest %0d",
                      rsp_data.result_value, rsp_data.result_dest);
               error_count <= error_count + 1;
            end else begin
               oldest = expected_results.pop_front();
               if (rsp_data.result_value !== oldest.result_value) begin
                  $error("result_value: expected %h, actual %h",
                         oldest.result_value, rsp_data.result_value);
                  error_count <= error_count + 1;
               end else if (rsp_data.result_dest !== oldest.result_dest) begin
                  $error("result_dest: expected %0d, actual %0d",
                         oldest.result_dest, rsp_data.result_dest);
                  error_count <= error_count + 1;
               end
            end
         end
         pending_count <= expected_results.size();
      end
   end

endmodule

[sim/tb_rv64m_mul_div_unit.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// RV64M multiply/divide unit testbench
// Directed corner operands, then random transactions with random gaps on both
// queue ports; a checker module compares every result in order.
// ---------------------------------------------------------------------------
module tb_rv64m_mul_div_unit;

   localparam int RANDOM_COUNT = 900;
   localparam int DRAIN_CYCLES = 200;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_push = 1'b0;
   logic req_full;
   mvd_pkg::req_type req_data = '0;
   logic rsp_empty;
   logic rsp_pop = 1'b0;
   mvd_pkg::rsp_type rsp_data;
   int error_count;
   int pending_count;
   int result_count;
   int sent_count = 0;

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   rv64m_mul_div_unit dut (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data)
   );

   rv64m_mul_div_checker checker_inst (
      .clock(clock), .reset(reset),
      .req_push(req_push), .req_full(req_full), .req_data(req_data),
      .rsp_empty(rsp_empty), .rsp_pop(rsp_pop), .rsp_data(rsp_data),
      .error_count(error_count), .pending_count(pending_count),
      .result_count(result_count)
   );

   function automatic int gap_length();
      if ($urandom_range(0, 19) == 0) begin
         return $urandom_range(10, 80);
      end
      return ($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0;
   endfunction

   function automatic logic [63:0] corner_operand();
      case ($urandom_range(0, 11))
         0: return 64'd0;
         1: return 64'd1;
         2: return '1;
         3: return 64'h8000_0000_0000_0000;
         4: return 64'h7FFF_FFFF_FFFF_FFFF;
         5: return 64'h0000_0000_8000_0000;
         6: return 64'hFFFF_FFFF_FFFF_FFFF ^ 64'h0000_0000_FFFF_FFFE;
         7: return {$urandom(), 32'd0};
         8: return {32'd0, $urandom()};
         9: return 64'($urandom_range(0, 20));
         default: return {$urandom(), $urandom()};
      endcase
   endfunction

   task automatic send(input logic [3:0] kind, input logic [63:0] a, input logic [63:0] b,
                       input logic [4:0] dest);
      req_push <= 1'b1;
      req_data <= '{kind: kind, operand_a: a, operand_b: b, dest_reg: dest};
      @(posedge clock);
      while (req_full) begin
         @(posedge clock);
      end
      sent_count++;
   endtask

   task automatic idle_sender(input int cycles);
      if (cycles > 0) begin
         req_push <= 1'b0;
         repeat (cycles) @(posedge clock);
      end
   endtask

   initial begin
      int stall;
      forever begin
         @(posedge clock);
         if (stall > 0) begin
            stall--;
            rsp_pop <= 1'b0;
         end else begin
            rsp_pop <= 1'b1;
            if ($urandom_range(0, 3) == 0) begin
               stall = gap_length();
            end
         end
      end
   end

   initial begin
      logic [63:0] min_word_ext;
      min_word_ext = 64'hFFFF_FFFF_8000_0000;
      repeat (3) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      send(mvd_pkg::KIND_MUL, '1, '1, 5'd0);
      send(mvd_pkg::KIND_MULH, 64'h8000_0000_0000_0000, 64'h8000_0000_0000_0000, 5'd31);
      send(mvd_pkg::KIND_MULHSU, '1, '1, 5'd1);
      send(mvd_pkg::KIND_MULHU, '1, '1, 5'd2);
      send(mvd_pkg::KIND_DIV, 64'd7, 64'd0, 5'd3);
      send(mvd_pkg::KIND_DIV, 64'h8000_0000_0000_0000, '1, 5'd4);
      send(mvd_pkg::KIND_DIVU, 64'd5, 64'd0, 5'd5);
      send(mvd_pkg::KIND_REM, 64'h1234, 64'd0, 5'd6);
      send(mvd_pkg::KIND_REM, 64'h8000_0000_0000_0000, '1, 5'd7);
      send(mvd_pkg::KIND_REMU, '1, 64'd0, 5'd8);
      send(mvd_pkg::KIND_MULW, 64'h0000_0000_FFFF_FFFF, 64'h0000_0000_7FFF_FFFF, 5'd9);
      send(mvd_pkg::KIND_DIVW, 64'h1_0000_0009, 64'hF_0000_0000, 5'd10);
      send(mvd_pkg::KIND_DIVW, min_word_ext, '1, 5'd11);
      send(mvd_pkg::KIND_DIVUW, 64'h8000_0000, 64'hFFFF_0000_0000, 5'd12);
      send(mvd_pkg::KIND_REMW, 64'h0000_0000_8000_0005, 64'd0, 5'd13);
      send(mvd_pkg::KIND_REMW, 64'h0000_0000_8000_0000, '1, 5'd14);
      send(mvd_pkg::KIND_REMUW, 64'hAB_8000_0001, 64'd0, 5'd15);
      send(mvd_pkg::KIND_REMUW, '1, 64'd3, 5'd16);
      send(4'd13, '1, '1, 5'd17);
      send(4'd15, 64'd1, 64'd2, 5'd18);
      send(mvd_pkg::KIND_DIV, -64'sd7, 64'd2, 5'd19);
      send(mvd_pkg::KIND_REM, -64'sd7, 64'd2, 5'd20);
      idle_sender(1);
      while (pending_count != 0) begin
         @(posedge clock);
      end
      for (int i = 0; i < RANDOM_COUNT; i++) begin
         send($urandom_range(0, 19) == 0 ? 4'($urandom_range(13, 15))
                                          : 4'($urandom_range(0, 12)),
              corner_operand(), corner_operand(), 5'($urandom()));
         idle_sender(gap_length());
      end
      req_push <= 1'b0;
      while (pending_count != 0) begin
         @(posedge clock);
      end
      repeat (DRAIN_CYCLES) @(posedge clock);
      $display("Sent %0d transactions (all 13 operations, unused codes, zero divisors,",
               sent_count);
      $display("signed overflow) and checked %0d results.", result_count);
      if (error_count == 0 && pending_count == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #5ms;
      $display("CHECK FAILED");
      $finish;
   end

endmodule

[filelist.f]
design/mvd_pkg.sv
design/mvd_fifo.sv
design/mvd_front.sv
design/mvd_back.sv
design/rv64m_mul_div_unit.sv
sim/rv64m_mul_div_checker.sv
sim/tb_rv64m_mul_div_unit.sv
